/* rtl/core/ins_pkg.sv */
// ============================================================================
// ins_pkg
// Shared widths, state encoding and inter-module structs of the block sorter.
// ============================================================================
`default_nettype none

package ins_pkg;

    localparam int DEPTH    = 64;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SWAP_W   = 11;
    localparam int SWAP_MAX = DEPTH * (DEPTH - 1) / 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_PLACE,
        S_EMIT
    } state_t;

    // Store access issued by the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // Sideband of one output beat, issued with the store read
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [SWAP_W-1:0] swap_total;
        logic              dropped;
    } emit_t;

endpackage

`default_nettype wire

/* rtl/core/ins_ram.sv */
// ============================================================================
// ins_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module ins_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/ins_ctrl.sv */
// ============================================================================
// ins_ctrl
// Insertion sequencer: walks the sorted store downward one entry per cycle,
// shifting larger entries up, then reads the block out in order.
// ============================================================================
`default_nettype none

module ins_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic signed [31:0]          value,
    input  wire logic                        last_item,
    output logic                             busy,
    output ins_pkg::ram_req_t                ram_req,
    input  wire logic [ins_pkg::DATA_W-1:0]  rdata,
    output ins_pkg::emit_t                   emit
);

    ins_pkg::state_t               state_reg, state_next;
    logic [ins_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [ins_pkg::CNT_W-1:0]     idx_reg, idx_next;
    logic [ins_pkg::SWAP_W-1:0]    swap_reg, swap_next;
    logic                          ovf_reg, ovf_next;
    logic [ins_pkg::ADDR_W-1:0]    pos_reg, pos_next;
    logic [ins_pkg::DATA_W-1:0]    val_reg, val_next;
    logic                          last_reg, last_next;
    logic                          fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ins_pkg::S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            swap_reg  <= '0;
            ovf_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            swap_reg  <= swap_next;
            ovf_reg   <= ovf_next;
            last_reg  <= last_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        val_reg <= val_next;
    end

    assign fin = ((idx_reg + ins_pkg::CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        swap_next  = swap_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        ram_req    = '0;
        emit       = '0;

        case (state_reg)
            ins_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (count_reg < ins_pkg::CNT_W'(ins_pkg::DEPTH))
                    begin
                        val_next  = $unsigned(value);
                        last_next = last_item;
                        if (count_reg == '0)
                        begin
                            // empty store: place directly
                            ram_req.we    = 1'b1;
                            ram_req.waddr = '0;
                            ram_req.wdata = $unsigned(value);
                            count_next    = ins_pkg::CNT_W'(1);
                            if (last_item)
                            begin
                                idx_next   = '0;
                                state_next = ins_pkg::S_EMIT;
                            end
                        end
                        else
                        begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = ins_pkg::ADDR_W'(count_reg - ins_pkg::CNT_W'(1));
                            pos_next      = ins_pkg::ADDR_W'(count_reg);
                            state_next    = ins_pkg::S_SEARCH;
                        end
                    end
                    else
                    begin
                        // store full: drop the beat
                        ovf_next = 1'b1;
                        if (last_item)
                        begin
                            idx_next   = '0;
                            state_next = ins_pkg::S_EMIT;
                        end
                    end
                end
            end

            ins_pkg::S_SEARCH:
            begin
                // rdata holds store[pos-1]
                if ($signed(rdata) > $signed(val_reg))
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pos_reg;
                    ram_req.wdata = rdata;
                    swap_next     = swap_reg + ins_pkg::SWAP_W'(1);
                    pos_next      = pos_reg - ins_pkg::ADDR_W'(1);
                    if (pos_reg == ins_pkg::ADDR_W'(1))
                    begin
                        state_next = ins_pkg::S_PLACE;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = pos_reg - ins_pkg::ADDR_W'(2);
                    end
                end
                else
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pos_reg;
                    ram_req.wdata = val_reg;
                    count_next    = count_reg + ins_pkg::CNT_W'(1);
                    idx_next      = '0;
                    state_next    = last_reg ? ins_pkg::S_EMIT : ins_pkg::S_IDLE;
                end
            end

            ins_pkg::S_PLACE:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = pos_reg;
                ram_req.wdata = val_reg;
                count_next    = count_reg + ins_pkg::CNT_W'(1);
                idx_next      = '0;
                state_next    = last_reg ? ins_pkg::S_EMIT : ins_pkg::S_IDLE;
            end

            ins_pkg::S_EMIT:
            begin
                ram_req.re      = 1'b1;
                ram_req.raddr   = idx_reg[ins_pkg::ADDR_W-1:0];
                emit.valid      = 1'b1;
                emit.last       = fin;
                emit.swap_total = fin ? swap_reg : '0;
                emit.dropped    = ovf_reg;
                if (fin)
                begin
                    count_next = '0;
                    swap_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = ins_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + ins_pkg::CNT_W'(1);
                end
            end

            default:
            begin
                state_next = ins_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ins_pkg::S_IDLE);

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ins_pkg::CNT_W'(ins_pkg::DEPTH))
        else $error("element count beyond store depth");

    a_swap_range: assert property (@(posedge clk) disable iff (!rst_n)
        swap_reg <= ins_pkg::SWAP_W'(ins_pkg::SWAP_MAX))
        else $error("swap count beyond inversion bound");

    a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
        else $error("store read and write hit the same entry");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ins_pkg::S_EMIT) |-> (idx_reg < count_reg))
        else $error("readout beyond stored elements");

    a_search_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ins_pkg::S_SEARCH) |-> (pos_reg != '0))
        else $error("search below bottom of store");
`endif

endmodule

`default_nettype wire

/* rtl/core/insertion_sorter.sv */
// ============================================================================
// insertion_sorter
// Block sorter: inserts each arriving element into a sorted store by
// adjacent swaps, counts the swaps, and plays the block out ascending.
// ============================================================================
// Usage:
//   Input beat: value/last_item are taken at a clock edge with start high and
//   busy low. last_item marks the final element of a block.
//   Output beat: strobe is high for one cycle with sorted_value, last_out,
//   swap_total and dropped; the receiver cannot stall, so every beat must be
//   taken when shown. swap_total is nonzero only on the last_out beat;
//   dropped is set on every beat of a block that lost elements.
// Timing:
//   The first element of a block is placed in the accept cycle (busy stays
//   low). Every later element keeps busy high until it is placed, after one
//   shift for each stored element greater than it: the store is read one
//   entry per cycle and each larger entry is written one slot up in the cycle
//   after its read, so the single RAM read port sets the pace. An element
//   arriving at a full store (DEPTH entries) is discarded in its accept cycle.
//   On last_item the block is read out one entry per cycle; each beat appears
//   in the cycle after its read, as the RAM read is registered.
//   The next block may start as soon as busy drops.
// Reset:
//   rst_n clears the element count, swap count and overflow flag; the store
//   itself is not cleared and is only read below the element count.
// ============================================================================
`default_nettype none

module insertion_sorter (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] value,
    input  wire logic               last_item,
    output logic                    strobe,
    output logic signed [31:0]      sorted_value,
    output logic                    last_out,
    output logic [10:0]             swap_total,
    output logic                    dropped
);

    ins_pkg::ram_req_t              ram_req;
    ins_pkg::emit_t                 emit;
    logic [ins_pkg::DATA_W-1:0]     rdata;

    logic                           strobe_reg;
    logic                           last_out_reg;
    logic [ins_pkg::SWAP_W-1:0]     swap_total_reg;
    logic                           dropped_reg;

    ins_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .value     (value),
        .last_item (last_item),
        .busy      (busy),
        .ram_req   (ram_req),
        .rdata     (rdata),
        .emit      (emit)
    );

    // Sorted element store
    ins_ram #(
        .WIDTH (ins_pkg::DATA_W),
        .DEPTH (ins_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (rdata)
    );

    // Sideband registered to line up with the registered read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        last_out_reg   <= emit.last;
        swap_total_reg <= emit.swap_total;
        dropped_reg    <= emit.dropped;
    end

    assign strobe       = strobe_reg;
    assign sorted_value = $signed(rdata);
    assign last_out     = strobe_reg & last_out_reg;
    assign swap_total   = strobe_reg ? swap_total_reg : '0;
    assign dropped      = strobe_reg & dropped_reg;

endmodule

`default_nettype wire
